[rtl/reno_congestion_window_controller_assert.svh]
// Assertion macros used by the checker module of the congestion window controller.
`ifndef RENO_CONGESTION_WINDOW_CONTROLLER_ASSERT_SVH
`define RENO_CONGESTION_WINDOW_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define RCWC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define RCWC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rcwc_pkg.sv]
// Types and constants of the congestion window controller.
package rcwc_pkg;

    localparam int CWND_MAX   = 1023;
    localparam int BASE_BITS  = 16;
    localparam int CWND_W     = 10;
    localparam int THRESH_W   = 10;
    localparam int DUP_W      = 8;
    localparam int AVOID_W    = 10;
    localparam int BASE_OUT_W = 16;

    localparam int CWND_CAP_INT = (CWND_MAX < 1023) ? CWND_MAX : 1023;
    localparam logic [CWND_W-1:0]   CWND_CAP        = CWND_W'(CWND_CAP_INT);
    localparam logic [THRESH_W-1:0] INIT_THRESH_RST = THRESH_W'(16);
    localparam logic [DUP_W-1:0]    DUP_SAT         = '1;
    localparam logic [AVOID_W-1:0]  AVOID_SAT       = '1;
    localparam logic [15:0]         CSUM_GOOD       = 16'hffff;

    typedef enum logic [1:0] {
        KIND_RESTART = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_TIMEOUT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        RESEND_NONE    = 2'd0,
        RESEND_FAST    = 2'd1,
        RESEND_GO_BACK = 2'd2
    } t_resend;

    typedef enum logic [3:0] {
        EV_BAD_CSUM     = 4'd0,
        EV_RECOVERY_END = 4'd1,
        EV_SLOW_START   = 4'd2,
        EV_CA_GROW      = 4'd3,
        EV_CA_HOLD      = 4'd4,
        EV_DUP          = 4'd5,
        EV_TRIPLE_DUP   = 4'd6,
        EV_INFLATE      = 4'd7,
        EV_CAPPED       = 4'd8,
        EV_TIMEOUT      = 4'd9,
        EV_RESTART      = 4'd10
    } t_event;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] hdr_checksum;
        logic [15:0] hdr_length;
        logic [7:0]  hdr_seq;
        logic [7:0]  hdr_ack;
        logic [7:0]  hdr_flag;
        logic [7:0]  hdr_pad;
    } t_req;

    typedef struct packed {
        logic [BASE_OUT_W-1:0] window_base_out;
        logic [CWND_W-1:0]     cwnd_out;
        logic [THRESH_W-1:0]   threshold_out;
        logic [1:0]            resend_action;
        logic [3:0]            event_code;
    } t_rsp;

endpackage

[rtl/rcwc_if.sv]
// Valid/ready channel interfaces for requests, results and the threshold write.
interface rcwc_req_if;
    logic              valid;
    logic              ready;
    rcwc_pkg::t_req    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rcwc_rsp_if;
    logic              valid;
    logic              ready;
    rcwc_pkg::t_rsp    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rcwc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rcwc_pkg::THRESH_W-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/reno_congestion_window_controller.sv]
// Reno-style sender congestion window controller: request register, update, result register.
//
// Usage:
// i_req carries one request per handshake: a restart, a received ACK header
// (four 16-bit words that must sum to all ones in one's complement), or a
// retransmit timeout. o_rsp returns exactly one result per request with the
// window base, cwnd, ssthresh, the resend action and an event code.
// i_cfg writes the slow start threshold that a restart loads. It is always
// ready; the user must write it only while no request is in flight, since the
// block does not enforce this. A request sits in the request register, and
// the window state and the result register then load together once the
// result register can load. Throughput is one request per cycle while the
// receiver does not stall, set by the single state update between the two registers.
// When the receiver stalls, the result register holds its result and the
// request register fills; i_req.ready drops only when both are full.
// Reset (synchronous, active low) empties both registers, sets cwnd and the
// avoidance counter to one, clears base, last ACK and duplicate count, and
// sets the programmed and working thresholds to 16.
module reno_congestion_window_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcwc_req_if.sink    i_req,
    rcwc_cfg_if.sink    i_cfg,
    rcwc_rsp_if.source  o_rsp
);

    // Request stage.
    logic                             r_in_valid;
    rcwc_pkg::t_req                   r_item;

    // Result stage.
    logic                             r_out_valid;
    rcwc_pkg::t_rsp                   r_result;
    rcwc_pkg::t_rsp                   n_result;

    // Programmed threshold and window state.
    logic [rcwc_pkg::THRESH_W-1:0]    r_init_thresh;
    logic [rcwc_pkg::BASE_BITS-1:0]   r_window_base, n_window_base;
    logic [rcwc_pkg::CWND_W-1:0]      r_cwnd, n_cwnd;
    logic [rcwc_pkg::THRESH_W-1:0]    r_threshold, n_threshold;
    logic [7:0]                       r_prev_ack, n_prev_ack;
    logic [rcwc_pkg::DUP_W-1:0]       r_dup_count, n_dup_count;
    logic [rcwc_pkg::AVOID_W-1:0]     r_avoid_cnt, n_avoid_cnt;

    logic                             advance;
    logic                             do_update;
    logic                             csum_ok;
    logic [15:0]                      csum;
    logic [7:0]                       base_step;
    logic [rcwc_pkg::DUP_W-1:0]       dup_inc;
    logic [rcwc_pkg::THRESH_W:0]      thresh_plus3;
    logic [rcwc_pkg::THRESH_W:0]      half_plus3;
    logic [rcwc_pkg::THRESH_W-1:0]    half_cwnd;
    logic [rcwc_pkg::CWND_W-1:0]      cwnd_grown;

    // The result register can load when it is empty or being drained.
    assign advance     = !r_out_valid || o_rsp.ready;
    assign do_update   = r_in_valid && advance;
    assign i_req.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_result;

    // One's complement sum over the four header words, folding the carry
    // back in after each addition as the header check does.
    always_comb begin
        logic [15:0] words [4];
        logic [16:0] acc;
        words[0] = r_item.hdr_checksum;
        words[1] = r_item.hdr_length;
        words[2] = {r_item.hdr_ack, r_item.hdr_seq};
        words[3] = {r_item.hdr_pad, r_item.hdr_flag};
        acc = '0;
        for (int k = 0; k < 4; k++) begin
            acc = {1'b0, acc[15:0]} + {1'b0, words[k]};
            if (acc[16]) begin
                acc = {1'b0, acc[15:0]} + 17'd1;
            end
        end
        csum = acc[15:0];
    end

    assign csum_ok = (csum == rcwc_pkg::CSUM_GOOD);

    // Distance from the base's low byte to the acknowledged number, mod 256.
    assign base_step = r_item.hdr_ack - r_window_base[7:0];

    assign dup_inc      = (r_dup_count != rcwc_pkg::DUP_SAT) ? r_dup_count + 1'b1 : r_dup_count;
    assign half_cwnd    = rcwc_pkg::THRESH_W'(r_cwnd >> 1);
    assign half_plus3   = {1'b0, half_cwnd} + (rcwc_pkg::THRESH_W+1)'(3);
    assign thresh_plus3 = {1'b0, r_threshold} + (rcwc_pkg::THRESH_W+1)'(3);
    assign cwnd_grown   = (r_cwnd < rcwc_pkg::CWND_CAP) ? r_cwnd + 1'b1 : rcwc_pkg::CWND_CAP;

    // Window update for the request in the request register.
    always_comb begin
        n_window_base = r_window_base;
        n_cwnd        = r_cwnd;
        n_threshold   = r_threshold;
        n_prev_ack    = r_prev_ack;
        n_dup_count   = r_dup_count;
        n_avoid_cnt   = r_avoid_cnt;
        n_result.resend_action = rcwc_pkg::RESEND_NONE;
        n_result.event_code    = rcwc_pkg::EV_BAD_CSUM;

        unique case (r_item.kind)
            rcwc_pkg::KIND_RESTART: begin
                n_window_base = '0;
                n_cwnd        = rcwc_pkg::CWND_W'(1);
                n_threshold   = r_init_thresh;
                n_prev_ack    = '0;
                n_dup_count   = '0;
                n_avoid_cnt   = rcwc_pkg::AVOID_W'(1);
                n_result.event_code = rcwc_pkg::EV_RESTART;
            end
            rcwc_pkg::KIND_TIMEOUT: begin
                n_threshold = half_cwnd;
                n_cwnd      = rcwc_pkg::CWND_W'(1);
                n_dup_count = '0;
                n_result.resend_action = rcwc_pkg::RESEND_GO_BACK;
                n_result.event_code    = rcwc_pkg::EV_TIMEOUT;
            end
            rcwc_pkg::KIND_ACK: begin
                if (!csum_ok) begin
                    n_result.event_code = rcwc_pkg::EV_BAD_CSUM;
                end else if (r_item.hdr_ack != r_prev_ack) begin
                    // New ACK: slide the base, then pick the growth rule.
                    n_window_base = r_window_base + rcwc_pkg::BASE_BITS'(base_step);
                    n_prev_ack    = r_item.hdr_ack;
                    n_dup_count   = '0;
                    if (r_dup_count != '0) begin
                        n_cwnd = (r_threshold < rcwc_pkg::CWND_CAP) ?
                                 rcwc_pkg::CWND_W'(r_threshold) : rcwc_pkg::CWND_CAP;
                        n_result.event_code = rcwc_pkg::EV_RECOVERY_END;
                    end else if (r_cwnd < r_threshold) begin
                        n_cwnd = cwnd_grown;
                        n_result.event_code = rcwc_pkg::EV_SLOW_START;
                    end else if (r_avoid_cnt >= rcwc_pkg::AVOID_W'(r_cwnd)) begin
                        n_cwnd      = cwnd_grown;
                        n_avoid_cnt = rcwc_pkg::AVOID_W'(1);
                        n_result.event_code = rcwc_pkg::EV_CA_GROW;
                    end else begin
                        if (r_avoid_cnt != rcwc_pkg::AVOID_SAT) begin
                            n_avoid_cnt = r_avoid_cnt + 1'b1;
                        end
                        n_result.event_code = rcwc_pkg::EV_CA_HOLD;
                    end
                end else begin
                    // Duplicate ACK.
                    n_dup_count = dup_inc;
                    if (dup_inc < rcwc_pkg::DUP_W'(3)) begin
                        n_result.event_code = rcwc_pkg::EV_DUP;
                    end else if (dup_inc == rcwc_pkg::DUP_W'(3)) begin
                        n_threshold = half_cwnd;
                        n_cwnd = (half_plus3 < (rcwc_pkg::THRESH_W+1)'(rcwc_pkg::CWND_CAP)) ?
                                 rcwc_pkg::CWND_W'(half_plus3) : rcwc_pkg::CWND_CAP;
                        n_result.resend_action = rcwc_pkg::RESEND_FAST;
                        n_result.event_code    = rcwc_pkg::EV_TRIPLE_DUP;
                    end else if ((rcwc_pkg::THRESH_W+1)'(dup_inc) > thresh_plus3) begin
                        n_result.event_code = rcwc_pkg::EV_CAPPED;
                    end else begin
                        n_cwnd = cwnd_grown;
                        n_result.event_code = rcwc_pkg::EV_INFLATE;
                    end
                end
            end
            default: begin
                // Unused kind leaves the state alone and reports it.
                n_result.event_code = rcwc_pkg::EV_BAD_CSUM;
            end
        endcase

        n_result.window_base_out = rcwc_pkg::BASE_OUT_W'(n_window_base);
        n_result.cwnd_out        = n_cwnd;
        n_result.threshold_out   = n_threshold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_init_thresh <= rcwc_pkg::INIT_THRESH_RST;
            r_window_base <= '0;
            r_cwnd        <= rcwc_pkg::CWND_W'(1);
            r_threshold   <= rcwc_pkg::INIT_THRESH_RST;
            r_prev_ack    <= '0;
            r_dup_count   <= '0;
            r_avoid_cnt   <= rcwc_pkg::AVOID_W'(1);
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg.valid) begin
                r_init_thresh <= i_cfg.data;
            end
            if (do_update) begin
                r_window_base <= n_window_base;
                r_cwnd        <= n_cwnd;
                r_threshold   <= n_threshold;
                r_prev_ack    <= n_prev_ack;
                r_dup_count   <= n_dup_count;
                r_avoid_cnt   <= n_avoid_cnt;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item <= i_req.payload;
        end
        if (do_update) begin
            r_result <= n_result;
        end
    end

endmodule

[rtl/rcwc_checker.sv]
// Port-level checker for the congestion window controller and its bind.
`include "reno_congestion_window_controller_assert.svh"

module rcwc_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            i_ready,
    input rcwc_pkg::t_rsp  i_rsp
);

    // A fast retransmit is requested exactly on the third duplicate.
    `RCWC_ASSERT_IMP(a_fast_on_triple, i_valid, ((i_rsp.resend_action == rcwc_pkg::RESEND_FAST) == (i_rsp.event_code == rcwc_pkg::EV_TRIPLE_DUP)), "fast retransmit and triple duplicate disagree")

    // A go-back is requested exactly on a timeout, which leaves cwnd at one.
    `RCWC_ASSERT_IMP(a_goback_on_timeout, i_valid, ((i_rsp.resend_action == rcwc_pkg::RESEND_GO_BACK) == (i_rsp.event_code == rcwc_pkg::EV_TIMEOUT)), "go-back and timeout disagree")
    `RCWC_ASSERT_IMP(a_timeout_cwnd, i_valid && (i_rsp.event_code == rcwc_pkg::EV_TIMEOUT), (i_rsp.cwnd_out == rcwc_pkg::CWND_W'(1)), "timeout result with cwnd not one")

    // A restart reports a fresh window.
    `RCWC_ASSERT_IMP(a_restart_state, i_valid && (i_rsp.event_code == rcwc_pkg::EV_RESTART), (i_rsp.cwnd_out == rcwc_pkg::CWND_W'(1)) && (i_rsp.window_base_out == '0), "restart result with stale window")

    // A stalled result stays put.
    `RCWC_ASSERT_NXT(a_rsp_hold, i_valid && !i_ready, i_valid && $stable(i_rsp), "stalled result changed")

endmodule

bind reno_congestion_window_controller rcwc_checker u_rcwc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_rsp.valid),
    .i_ready (o_rsp.ready),
    .i_rsp   (o_rsp.payload)
);
